/* hdl/tank_fill_level_controller_top_assert.svh */
// assertion macros shared by the tank fill level controller checker
`ifndef TANK_FILL_LEVEL_CONTROLLER_TOP_ASSERT_SVH
`define TANK_FILL_LEVEL_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TFLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tflc assertion failed");

// next-cycle implication, checked out of reset
`define TFLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tflc assertion failed");

`endif

/* hdl/tflc_pkg.sv */
// types, constants and codes of the tank fill level controller
package tflc_pkg;

  // largest number of samples in one window
  localparam int MAX_WINDOW = 16;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int DIST_W     = 16;
  localparam int RDG_W      = 11;
  localparam int THK_W      = 12;
  localparam int SPW_W      = 5;
  localparam int LOSS_W     = 4;
  localparam int STAT_W     = 3;
  localparam int VC_W       = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // derived widths
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = RDG_W + $clog2(MAX_WINDOW);
  localparam int DIVC_W = $clog2(SUM_W);
  localparam int CMP_W  = (CNT_W > SPW_W) ? CNT_W : SPW_W;
  localparam int LVC_W  = THK_W + 2;

  // register reset values and the loss count ceiling
  localparam logic [SPW_W-1:0]  SPW_RESET   = SPW_W'(5);
  localparam logic [LOSS_W-1:0] LIMIT_RESET = LOSS_W'(6);
  localparam logic [RDG_W-1:0]  RANGE_RESET = RDG_W'(2000);
  localparam logic [LOSS_W-1:0] LOSS_MAX    = LOSS_W'(15);

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_ABORT  = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_IDLE     = 3'd0,
    ST_FILLING  = 3'd1,
    ST_REACHED  = 3'd2,
    ST_SIG_LOST = 3'd3,
    ST_ABORTED  = 3'd4,
    ST_REJECTED = 3'd5
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTAINER_ZERO    = 3'd0,
    CFG_FLOATER_THICKNESS = 3'd1,
    CFG_TARGET_LEVEL      = 3'd2,
    CFG_SAMPLES_PER_WIN   = 3'd3,
    CFG_LOSS_LIMIT        = 3'd4,
    CFG_RANGE_LIMIT       = 3'd5
  } cfg_idx_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_LEVEL
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic exec;
    logic div_step;
    logic level;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_stat_t;

endpackage

/* hdl/tflc_datapath.sv */
// datapath: configuration, window accumulators, serial divider and result register
module tflc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tflc_pkg::ctrl_cmd_t              ctrl_i,
  output tflc_pkg::dp_stat_t               stat_o,
  input  logic                             cfg_we_i,
  input  logic [tflc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tflc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [tflc_pkg::CMD_W-1:0]       cmd_i,
  input  logic [tflc_pkg::DIST_W-1:0]      distance_i,
  input  logic                             timed_out_i,
  output logic                             pump_on_o,
  output logic [tflc_pkg::STAT_W-1:0]      status_o,
  output logic                             window_done_o,
  output logic [tflc_pkg::RDG_W-1:0]       level_o,
  output logic [tflc_pkg::RDG_W-1:0]       average_o,
  output logic [tflc_pkg::RDG_W-1:0]       min_reading_o,
  output logic [tflc_pkg::RDG_W-1:0]       max_reading_o,
  output logic [tflc_pkg::VC_W-1:0]        valid_count_o,
  output logic [tflc_pkg::LOSS_W-1:0]      loss_count_o
);

  // configuration registers
  logic [tflc_pkg::RDG_W-1:0]  zero_q, target_q, range_q;
  logic [tflc_pkg::THK_W-1:0]  thick_q;
  logic [tflc_pkg::SPW_W-1:0]  spw_q;
  logic [tflc_pkg::LOSS_W-1:0] limit_q;

  // latched item
  logic [tflc_pkg::CMD_W-1:0]  item_cmd_q;
  logic [tflc_pkg::DIST_W-1:0] item_dist_q;
  logic                        item_tmo_q;

  // controller state
  logic                        run_q, run_d;
  logic [tflc_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic [tflc_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [tflc_pkg::RDG_W-1:0]  min_q, min_d, max_q, max_d;
  logic [tflc_pkg::CNT_W-1:0]  vld_q, vld_d;
  logic [tflc_pkg::LOSS_W-1:0] loss_q, loss_d;

  // serial divider
  logic [tflc_pkg::SUM_W-1:0]  quo_q, quo_d;
  logic [tflc_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [tflc_pkg::DIVC_W-1:0] dcnt_q, dcnt_d;
  logic [tflc_pkg::CNT_W:0]    trial;
  logic                        trial_ge;

  // sample evaluation
  logic                        smp_ok;
  logic [tflc_pkg::RDG_W-1:0]  smp;
  logic [tflc_pkg::SUM_W-1:0]  sum_acc;
  logic [tflc_pkg::RDG_W-1:0]  min_acc, max_acc;
  logic [tflc_pkg::CNT_W-1:0]  vld_acc, idx_inc;
  logic [tflc_pkg::CMP_W-1:0]  win, spw_c, idx_c;
  logic                        win_end, need_div;
  logic [tflc_pkg::LOSS_W-1:0] loss_inc;

  // start check and level arithmetic
  logic signed [tflc_pkg::LVC_W-1:0] zero_s, thick_s, target_s, avg_s, bound_s, lvl_s;
  logic [tflc_pkg::LVC_W-2:0]        lvl_pos;
  logic                              reject;
  logic [tflc_pkg::RDG_W-1:0]        avg;

  // result values
  logic                        out_wr;
  logic [tflc_pkg::STAT_W-1:0] r_status;
  logic                        r_done;
  logic [tflc_pkg::RDG_W-1:0]  r_lvl, r_avg, r_min, r_max;
  logic [tflc_pkg::VC_W-1:0]   r_vc;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q   <= '0;
      thick_q  <= '0;
      target_q <= '0;
      spw_q    <= tflc_pkg::SPW_RESET;
      limit_q  <= tflc_pkg::LIMIT_RESET;
      range_q  <= tflc_pkg::RANGE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tflc_pkg::CFG_CONTAINER_ZERO:    zero_q   <= cfg_data_i[tflc_pkg::RDG_W-1:0];
        tflc_pkg::CFG_FLOATER_THICKNESS: thick_q  <= cfg_data_i[tflc_pkg::THK_W-1:0];
        tflc_pkg::CFG_TARGET_LEVEL:      target_q <= cfg_data_i[tflc_pkg::RDG_W-1:0];
        tflc_pkg::CFG_SAMPLES_PER_WIN:   spw_q    <= cfg_data_i[tflc_pkg::SPW_W-1:0];
        tflc_pkg::CFG_LOSS_LIMIT:        limit_q  <= cfg_data_i[tflc_pkg::LOSS_W-1:0];
        tflc_pkg::CFG_RANGE_LIMIT:       range_q  <= cfg_data_i[tflc_pkg::RDG_W-1:0];
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      item_cmd_q  <= cmd_i;
      item_dist_q <= distance_i;
      item_tmo_q  <= timed_out_i;
    end
  end

  // sample validity and window accumulation
  always_comb begin
    smp     = item_dist_q[tflc_pkg::RDG_W-1:0];
    smp_ok  = !item_tmo_q && (item_dist_q != '0) &&
              (item_dist_q < {{(tflc_pkg::DIST_W-tflc_pkg::RDG_W){1'b0}}, range_q});
    sum_acc = smp_ok ? sum_q + {{(tflc_pkg::SUM_W-tflc_pkg::RDG_W){1'b0}}, smp} : sum_q;
    min_acc = (smp_ok && smp < min_q) ? smp : min_q;
    max_acc = (smp_ok && smp > max_q) ? smp : max_q;
    vld_acc = smp_ok ? vld_q + tflc_pkg::CNT_W'(1) : vld_q;
    idx_inc = idx_q + tflc_pkg::CNT_W'(1);
    spw_c   = tflc_pkg::CMP_W'(spw_q);
    if (spw_c == '0) begin
      win = tflc_pkg::CMP_W'(1);
    end else if (spw_c > tflc_pkg::CMP_W'(tflc_pkg::MAX_WINDOW)) begin
      win = tflc_pkg::CMP_W'(tflc_pkg::MAX_WINDOW);
    end else begin
      win = spw_c;
    end
    idx_c    = tflc_pkg::CMP_W'(idx_inc);
    win_end  = idx_c >= win;
    need_div = (item_cmd_q == tflc_pkg::CMD_SAMPLE) && run_q && win_end && (vld_acc != '0);
    loss_inc = (loss_q < tflc_pkg::LOSS_MAX) ? loss_q + tflc_pkg::LOSS_W'(1) : loss_q;
  end

  // start check and level from the quotient
  always_comb begin
    zero_s   = $signed({{(tflc_pkg::LVC_W-tflc_pkg::RDG_W){1'b0}}, zero_q});
    target_s = $signed({{(tflc_pkg::LVC_W-tflc_pkg::RDG_W){1'b0}}, target_q});
    thick_s  = $signed({{(tflc_pkg::LVC_W-tflc_pkg::THK_W){thick_q[tflc_pkg::THK_W-1]}},
                        thick_q});
    avg      = quo_q[tflc_pkg::RDG_W-1:0];
    avg_s    = $signed({{(tflc_pkg::LVC_W-tflc_pkg::RDG_W){1'b0}}, avg});
    bound_s  = zero_s - thick_s;
    reject   = (zero_q == '0) || (thick_q == '0) || (target_s > bound_s);
    lvl_s    = zero_s - (avg_s + thick_s);
    lvl_pos  = lvl_s[tflc_pkg::LVC_W-1] ? '0 : lvl_s[tflc_pkg::LVC_W-2:0];
  end

  // restoring divider step
  always_comb begin
    trial    = {rem_q, quo_q[tflc_pkg::SUM_W-1]};
    trial_ge = trial >= {1'b0, vld_q};
  end

  // state update and result selection
  always_comb begin
    run_d  = run_q;
    idx_d  = idx_q;
    sum_d  = sum_q;
    min_d  = min_q;
    max_d  = max_q;
    vld_d  = vld_q;
    loss_d = loss_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dcnt_d = dcnt_q;
    out_wr   = 1'b0;
    r_status = run_q ? tflc_pkg::ST_FILLING : tflc_pkg::ST_IDLE;
    r_done   = 1'b0;
    r_lvl    = '0;
    r_avg    = '0;
    r_min    = '0;
    r_max    = '0;
    r_vc     = '0;
    if (ctrl_i.exec) begin
      out_wr = !need_div;
      case (item_cmd_q)
        tflc_pkg::CMD_START: begin
          idx_d = '0;
          sum_d = '0;
          min_d = '1;
          max_d = '0;
          vld_d = '0;
          if (reject) begin
            run_d    = 1'b0;
            r_status = tflc_pkg::ST_REJECTED;
          end else begin
            run_d    = 1'b1;
            loss_d   = '0;
            r_status = tflc_pkg::ST_FILLING;
          end
        end
        tflc_pkg::CMD_ABORT: begin
          run_d    = 1'b0;
          idx_d    = '0;
          sum_d    = '0;
          min_d    = '1;
          max_d    = '0;
          vld_d    = '0;
          r_status = tflc_pkg::ST_ABORTED;
        end
        tflc_pkg::CMD_SAMPLE: begin
          if (run_q) begin
            if (!win_end || need_div) begin
              idx_d = idx_inc;
              sum_d = sum_acc;
              min_d = min_acc;
              max_d = max_acc;
              vld_d = vld_acc;
              // load the divider, used when the window closes with valid samples
              quo_d  = sum_acc;
              rem_d  = '0;
              dcnt_d = '0;
            end else begin
              // window without a valid sample
              idx_d  = '0;
              sum_d  = '0;
              min_d  = '1;
              max_d  = '0;
              vld_d  = '0;
              loss_d = loss_inc;
              r_done = 1'b1;
              if (loss_inc >= limit_q) begin
                run_d    = 1'b0;
                r_status = tflc_pkg::ST_SIG_LOST;
              end
            end
          end
        end
        default: ;
      endcase
    end else if (ctrl_i.div_step) begin
      quo_d  = {quo_q[tflc_pkg::SUM_W-2:0], trial_ge};
      rem_d  = trial_ge ? tflc_pkg::CNT_W'(trial - {1'b0, vld_q})
                        : trial[tflc_pkg::CNT_W-1:0];
      dcnt_d = dcnt_q + tflc_pkg::DIVC_W'(1);
    end else if (ctrl_i.level) begin
      out_wr = 1'b1;
      r_done = 1'b1;
      r_avg  = avg;
      r_min  = min_q;
      r_max  = max_q;
      r_vc   = tflc_pkg::VC_W'(vld_q);
      r_lvl  = (lvl_pos[tflc_pkg::LVC_W-2:tflc_pkg::RDG_W] != '0) ? '1
                                                                : lvl_pos[tflc_pkg::RDG_W-1:0];
      loss_d = '0;
      idx_d  = '0;
      sum_d  = '0;
      min_d  = '1;
      max_d  = '0;
      vld_d  = '0;
      if (lvl_pos >= {{(tflc_pkg::LVC_W-1-tflc_pkg::RDG_W){1'b0}}, target_q}) begin
        run_d    = 1'b0;
        r_status = tflc_pkg::ST_REACHED;
      end
    end
  end

  // window and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      idx_q  <= '0;
      sum_q  <= '0;
      min_q  <= '1;
      max_q  <= '0;
      vld_q  <= '0;
      loss_q <= '0;
    end else begin
      run_q  <= run_d;
      idx_q  <= idx_d;
      sum_q  <= sum_d;
      min_q  <= min_d;
      max_q  <= max_d;
      vld_q  <= vld_d;
      loss_q <= loss_d;
    end
  end

  // divider registers
  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dcnt_q <= dcnt_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      pump_on_o     <= run_d;
      status_o      <= r_status;
      window_done_o <= r_done;
      level_o       <= r_lvl;
      average_o     <= r_avg;
      min_reading_o <= r_min;
      max_reading_o <= r_max;
      valid_count_o <= r_vc;
      loss_count_o  <= loss_d;
    end
  end

  // status to the controller
  assign stat_o.need_div = need_div;
  assign stat_o.div_last = dcnt_q == tflc_pkg::DIVC_W'(tflc_pkg::SUM_W - 1);

endmodule

/* hdl/tflc_ctrl.sv */
// controller: item sequencing and output handshake
module tflc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  tflc_pkg::dp_stat_t   stat_i,
  output tflc_pkg::ctrl_cmd_t  ctrl_o
);

  tflc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  // result slot is free when empty or being taken now
  assign slot_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      tflc_pkg::S_IDLE: begin
        ctrl_o.load_item = in_valid_i;
        if (in_valid_i) begin
          state_d = tflc_pkg::S_EXEC;
        end
      end
      tflc_pkg::S_EXEC: begin
        if (slot_free) begin
          ctrl_o.exec = 1'b1;
          state_d     = stat_i.need_div ? tflc_pkg::S_DIV : tflc_pkg::S_IDLE;
        end
      end
      tflc_pkg::S_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = tflc_pkg::S_LEVEL;
        end
      end
      tflc_pkg::S_LEVEL: begin
        if (slot_free) begin
          ctrl_o.level = 1'b1;
          state_d      = tflc_pkg::S_IDLE;
        end
      end
      default: state_d = tflc_pkg::S_IDLE;
    endcase
    out_valid_d = (out_valid_q && out_stall_i) ||
                  (ctrl_o.exec && !stat_i.need_div) || ctrl_o.level;
  end

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tflc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != tflc_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

/* hdl/tank_fill_level_controller_top.sv */
// top level of the tank fill level controller
// Bang-bang pump fill controller. Each item (start, range sample or abort) gives
// exactly one result item. An item is taken in S_IDLE and executed in S_EXEC once
// the output register is free. A sample that closes a window with at least one
// valid reading computes the mean with a bit-serial restoring divider, one quotient
// bit per cycle over the 15-bit window sum, and then computes the level in S_LEVEL
// once the output register is free. A finished result waits in the output
// register while the next item is taken. Configuration writes are always ready and
// must only be made while no item is in flight.
module tank_fill_level_controller_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tflc_pkg::CMD_W-1:0]       cmd_i,
  input  logic [tflc_pkg::DIST_W-1:0]      distance_i,
  input  logic                             timed_out_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             pump_on_o,
  output logic [tflc_pkg::STAT_W-1:0]      status_o,
  output logic                             window_done_o,
  output logic [tflc_pkg::RDG_W-1:0]       level_o,
  output logic [tflc_pkg::RDG_W-1:0]       average_o,
  output logic [tflc_pkg::RDG_W-1:0]       min_reading_o,
  output logic [tflc_pkg::RDG_W-1:0]       max_reading_o,
  output logic [tflc_pkg::VC_W-1:0]        valid_count_o,
  output logic [tflc_pkg::LOSS_W-1:0]      loss_count_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tflc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tflc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  tflc_pkg::ctrl_cmd_t ctrl;
  tflc_pkg::dp_stat_t  stat;

  // configuration port never back-pressures
  assign cfg_ready_o = 1'b1;

  // sequencing
  tflc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // arithmetic and state
  tflc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .distance_i    (distance_i),
    .timed_out_i   (timed_out_i),
    .pump_on_o     (pump_on_o),
    .status_o      (status_o),
    .window_done_o (window_done_o),
    .level_o       (level_o),
    .average_o     (average_o),
    .min_reading_o (min_reading_o),
    .max_reading_o (max_reading_o),
    .valid_count_o (valid_count_o),
    .loss_count_o  (loss_count_o)
  );

endmodule

/* hdl/tflc_checker.sv */
// port-level checker for the tank fill level controller, bound to the top level
`include "tank_fill_level_controller_top_assert.svh"

module tflc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         pump_on_i,
  input  logic [tflc_pkg::STAT_W-1:0]  status_i,
  input  logic                         window_done_i,
  input  logic [tflc_pkg::RDG_W-1:0]   level_i,
  input  logic [tflc_pkg::RDG_W-1:0]   average_i,
  input  logic [tflc_pkg::RDG_W-1:0]   min_reading_i,
  input  logic [tflc_pkg::RDG_W-1:0]   max_reading_i,
  input  logic [tflc_pkg::VC_W-1:0]    valid_count_i
);

  logic out_take;
  assign out_take = out_valid_i && !out_stall_i;

  // a stalled result holds
  `TFLC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(status_i) && $stable(level_i))

  // one item at a time: taking an item closes the input
  `TFLC_ASSERT_NXT(a_in_busy, clk_i, rst_ni, in_valid_i && !in_stall_i, in_stall_i)

  // a running pump always reports filling
  `TFLC_ASSERT_IMP(a_pump_status, clk_i, rst_ni, out_take && pump_on_i, status_i == tflc_pkg::ST_FILLING)

  // no window figures without a completed window
  `TFLC_ASSERT_IMP(a_no_window, clk_i, rst_ni, out_take && !window_done_i, level_i == '0 && average_i == '0 && valid_count_i == '0)

  // an empty window reports zero figures
  `TFLC_ASSERT_IMP(a_empty_window, clk_i, rst_ni, out_take && valid_count_i == '0, min_reading_i == '0 && max_reading_i == '0 && level_i == '0)

endmodule

bind tank_fill_level_controller_top tflc_checker u_tflc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_i    (in_stall_o),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pump_on_i     (pump_on_o),
  .status_i      (status_o),
  .window_done_i (window_done_o),
  .level_i       (level_o),
  .average_i     (average_o),
  .min_reading_i (min_reading_o),
  .max_reading_i (max_reading_o),
  .valid_count_i (valid_count_o)
);

/* tb/tb.sv */
// tb: self-checking testbench for the tank fill level controller
module tb;
  import tflc_pkg::*;

  // undefined command code, not part of the package enum
  localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_CYCLES = 400;
  localparam int N_DIR       = 35;
  localparam logic ITEM = 1'b0;
  localparam logic SET  = 1'b1;
  localparam logic PRED = 1'b0;
  localparam logic CHK  = 1'b1;

  // one row of the directed table: a register write or an item
  typedef struct packed {
    logic                  is_cfg;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [CMD_W-1:0]      cmd;
    logic [DIST_W-1:0]     rdg;
    logic                  tmo;
    logic                  typed;
    logic                  pump;
    status_e               st;
  } step_t;

  // one result item
  typedef struct packed {
    logic              pump;
    status_e           st;
    logic              done;
    logic [RDG_W-1:0]  lvl;
    logic [RDG_W-1:0]  avg;
    logic [RDG_W-1:0]  mn;
    logic [RDG_W-1:0]  mx;
    logic [VC_W-1:0]   vc;
    logic [LOSS_W-1:0] loss;
  } fill_res_t;

  // block ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      cmd_i = '0;
  logic [DIST_W-1:0]     distance_i = '0;
  logic                  timed_out_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  pump_on_o;
  logic [STAT_W-1:0]     status_o;
  logic                  window_done_o;
  logic [RDG_W-1:0]      level_o;
  logic [RDG_W-1:0]      average_o;
  logic [RDG_W-1:0]      min_reading_o;
  logic [RDG_W-1:0]      max_reading_o;
  logic [VC_W-1:0]       valid_count_o;
  logic [LOSS_W-1:0]     loss_count_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // typed expectation travelling with a directed item
  logic    tag_typed = 1'b0;
  logic    tag_pump = 1'b0;
  status_e tag_status = ST_IDLE;

  // idling controls
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_kick = 1'b0;
  logic kick_seen = 1'b0;
  int   hold_len = 0;

  // mirrored registers
  logic [RDG_W-1:0]  zero_mm = '0;
  int                thick_mm = 0;
  logic [RDG_W-1:0]  target_mm = '0;
  logic [SPW_W-1:0]  win_cfg = SPW_RESET;
  logic [LOSS_W-1:0] loss_cfg = LIMIT_RESET;
  logic [RDG_W-1:0]  range_mm = RANGE_RESET;

  // mirrored controller state
  logic filling = 1'b0;
  int   samp_idx = 0;
  int   win_sum = 0;
  int   win_min = 65535;
  int   win_max = 0;
  int   win_good = 0;
  int   empty_run = 0;

  fill_res_t pending_reports [$];
  string     field_name [9] = '{"pump_on", "status", "window_done", "level", "average",
                                "min_reading", "max_reading", "valid_count", "loss_count"};
  int err_cnt = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_windows = 0;
  int n_reached = 0;
  int n_lost = 0;
  int n_rejected = 0;
  int n_aborts = 0;

  // directed table
  step_t dir_steps [N_DIR] = '{
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_UNDEF, 16'd0, 1'b0, CHK, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_SAMPLE, 16'd1, 1'b0, CHK, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_START, 16'd0, 1'b0, CHK, 1'b0, ST_REJECTED},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_ABORT, 16'd0, 1'b0, CHK, 1'b0, ST_ABORTED},
    '{SET, CFG_CONTAINER_ZERO, 12'd1500, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{SET, CFG_FLOATER_THICKNESS, 12'd100, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{SET, CFG_TARGET_LEVEL, 12'd2000, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    // target above the bound
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_START, 16'd0, 1'b0, CHK, 1'b0, ST_REJECTED},
    '{SET, CFG_TARGET_LEVEL, 12'd1000, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{SET, CFG_SAMPLES_PER_WIN, 12'd0, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{SET, CFG_LOSS_LIMIT, 12'd0, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_START, 16'd0, 1'b0, CHK, 1'b1, ST_FILLING},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_UNDEF, 16'hFFFF, 1'b1, CHK, 1'b1, ST_FILLING},
    // zero window size acts as one, zero loss limit halts at once
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_SAMPLE, 16'd0, 1'b0, CHK, 1'b0, ST_SIG_LOST},
    '{SET, CFG_SAMPLES_PER_WIN, 12'd2, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{SET, CFG_LOSS_LIMIT, 12'd15, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_START, 16'd0, 1'b0, CHK, 1'b1, ST_FILLING},
    // empty window from out of range and timed out readings
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_SAMPLE, 16'hFFFF, 1'b0, PRED, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_SAMPLE, 16'd1999, 1'b1, PRED, 1'b0, ST_IDLE},
    // restart while filling
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_START, 16'd0, 1'b0, CHK, 1'b1, ST_FILLING},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_SAMPLE, 16'd1, 1'b0, PRED, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_SAMPLE, 16'd1999, 1'b0, PRED, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_SAMPLE, 16'd1, 1'b0, PRED, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_SAMPLE, 16'd2, 1'b0, PRED, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_START, 16'd0, 1'b0, CHK, 1'b1, ST_FILLING},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_ABORT, 16'd0, 1'b0, CHK, 1'b0, ST_ABORTED},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_START, 16'd0, 1'b0, CHK, 1'b1, ST_FILLING},
    // rejected start while filling
    '{SET, CFG_FLOATER_THICKNESS, 12'd0, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_START, 16'd0, 1'b0, CHK, 1'b0, ST_REJECTED},
    // level beyond the field width
    '{SET, CFG_CONTAINER_ZERO, 12'd2047, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{SET, CFG_FLOATER_THICKNESS, 12'h800, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{SET, CFG_TARGET_LEVEL, 12'd0, CMD_START, 16'd0, 1'b0, PRED, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_START, 16'd0, 1'b0, CHK, 1'b1, ST_FILLING},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_SAMPLE, 16'd1, 1'b0, PRED, 1'b0, ST_IDLE},
    '{ITEM, CFG_CONTAINER_ZERO, 12'd0, CMD_SAMPLE, 16'd1, 1'b0, PRED, 1'b0, ST_IDLE}
  };

  tank_fill_level_controller_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .distance_i    (distance_i),
    .timed_out_i   (timed_out_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pump_on_o     (pump_on_o),
    .status_o      (status_o),
    .window_done_o (window_done_o),
    .level_o       (level_o),
    .average_o     (average_o),
    .min_reading_o (min_reading_o),
    .max_reading_o (max_reading_o),
    .valid_count_o (valid_count_o),
    .loss_count_o  (loss_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic void restart_window();
    samp_idx = 0;
    win_sum  = 0;
    win_min  = 65535;
    win_max  = 0;
    win_good = 0;
  endfunction

  // expected result of one item, advancing the mirrored state
  function automatic fill_res_t step_controller(logic [CMD_W-1:0] cmd,
                                                logic [DIST_W-1:0] rdg, logic tmo);
    fill_res_t r;
    int        win;
    int        lvl;
    int        mean;
    r = '0;
    r.st = filling ? ST_FILLING : ST_IDLE;
    case (cmd)
      CMD_START: begin
        if (zero_mm == 0 || thick_mm == 0 || int'(target_mm) > int'(zero_mm) - thick_mm) begin
          filling = 1'b0;
          r.st = ST_REJECTED;
        end else begin
          filling = 1'b1;
          empty_run = 0;
          r.st = ST_FILLING;
        end
        restart_window();
      end
      CMD_ABORT: begin
        filling = 1'b0;
        restart_window();
        r.st = ST_ABORTED;
      end
      CMD_SAMPLE: begin
        if (filling) begin
          // window size clamped to 1..MAX_WINDOW
          win = (win_cfg == 0) ? 1 : ((win_cfg > MAX_WINDOW) ? MAX_WINDOW : int'(win_cfg));
          if (!tmo && rdg != 0 && rdg < range_mm) begin
            win_sum += int'(rdg);
            if (int'(rdg) < win_min) win_min = int'(rdg);
            if (int'(rdg) > win_max) win_max = int'(rdg);
            win_good++;
          end
          samp_idx++;
          if (samp_idx >= win) begin
            r.done = 1'b1;
            r.vc = VC_W'(win_good);
            if (win_good == 0) begin
              if (empty_run < 15) empty_run++;
              if (empty_run >= int'(loss_cfg)) begin
                filling = 1'b0;
                r.st = ST_SIG_LOST;
              end
            end else begin
              empty_run = 0;
              mean = win_sum / win_good;
              r.avg = RDG_W'(mean);
              r.mn = RDG_W'(win_min);
              r.mx = RDG_W'(win_max);
              lvl = int'(zero_mm) - (mean + thick_mm);
              if (lvl < 0) lvl = 0;
              r.lvl = (lvl > 2047) ? RDG_W'(2047) : RDG_W'(lvl);
              if (lvl >= int'(target_mm)) begin
                filling = 1'b0;
                r.st = ST_REACHED;
              end
            end
            restart_window();
          end
        end
      end
      default: ;
    endcase
    r.pump = filling;
    r.loss = LOSS_W'(empty_run);
    return r;
  endfunction

  // receiver: random stall, or a long hold-off when kicked
  always @(posedge clk_i) begin
    if (hold_kick != kick_seen) begin
      kick_seen   <= hold_kick;
      hold_len    <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_len != 0) begin
      hold_len    <= hold_len - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checking, register mirror and expectation capture
  always @(posedge clk_i) begin : scoreboard
    fill_res_t   want;
    logic [15:0] got_f [9];
    logic [15:0] want_f [9];
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_reports.size() == 0) begin
          $error("result item with no item pending");
          err_cnt++;
        end else begin
          want = pending_reports.pop_front();
          got_f = '{pump_on_o, status_o, window_done_o, level_o, average_o,
                    min_reading_o, max_reading_o, valid_count_o, loss_count_o};
          want_f = '{want.pump, want.st, want.done, want.lvl, want.avg,
                     want.mn, want.mx, want.vc, want.loss};
          for (int k = 0; k < 9; k++) begin
            if (got_f[k] !== want_f[k]) begin
              $error("%s: expected %0d, got %0d", field_name[k], want_f[k], got_f[k]);
              err_cnt++;
            end
          end
          n_checked++;
          if (want.done) n_windows++;
          if (want.st == ST_REACHED) n_reached++;
          if (want.st == ST_SIG_LOST) n_lost++;
          if (want.st == ST_REJECTED) n_rejected++;
          if (want.st == ST_ABORTED) n_aborts++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CONTAINER_ZERO:    zero_mm = cfg_data_i[RDG_W-1:0];
          CFG_FLOATER_THICKNESS: thick_mm = int'($signed(cfg_data_i));
          CFG_TARGET_LEVEL:      target_mm = cfg_data_i[RDG_W-1:0];
          CFG_SAMPLES_PER_WIN:   win_cfg = cfg_data_i[SPW_W-1:0];
          CFG_LOSS_LIMIT:        loss_cfg = cfg_data_i[LOSS_W-1:0];
          CFG_RANGE_LIMIT:       range_mm = cfg_data_i[RDG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        want = step_controller(cmd_i, distance_i, timed_out_i);
        if (tag_typed) begin
          want.pump = tag_pump;
          want.st   = tag_status;
        end
        pending_reports.insert(pending_reports.size(), want);
        n_items++;
      end
    end
  end

  // offer one item, with random idle cycles first
  task automatic send_item(logic [CMD_W-1:0] c, logic [DIST_W-1:0] d, logic t,
                           logic typed = 1'b0, logic pump = 1'b0, status_e st = ST_IDLE);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    distance_i  <= d;
    timed_out_i <= t;
    tag_typed   <= typed;
    tag_pump    <= pump;
    tag_status  <= st;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and wait for every pending result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // stimulus
  initial begin
    int r;
    int sent;
    int len;
    int cz_v;
    int thk_v;
    int tgt_v;
    int spw_v;
    int lim_v;
    int rng_v;
    int win_v;
    int lo;
    int bound;
    logic [DIST_W-1:0] smp_mm;
    logic tmo;
    logic [CMD_W-1:0] c;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_steps[i].is_cfg) begin
        wait_drained();
        write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
      end else begin
        send_item(dir_steps[i].cmd, dir_steps[i].rdg, dir_steps[i].tmo,
                  dir_steps[i].typed, dir_steps[i].pump, dir_steps[i].st);
      end
    end

    // random phases, each with its own settings and idling mode
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      r = $urandom_range(99);
      cz_v = (r < 10) ? 0 : (r < 20) ? 2047 : $urandom_range(1, 2047);
      r = $urandom_range(99);
      thk_v = (r < 10) ? 0 : (r < 15) ? -2048 : (r < 20) ? 2047 :
              (r < 60) ? $urandom_range(1, 200) : -$urandom_range(1, 200);
      r = $urandom_range(99);
      spw_v = (r < 75) ? $urandom_range(0, 5) : $urandom_range(6, 31);
      r = $urandom_range(99);
      lim_v = (r < 10) ? 0 : (r < 20) ? 15 : $urandom_range(1, 6);
      r = $urandom_range(99);
      rng_v = (r < 8) ? 0 : (r < 14) ? 1 : (r < 20) ? 2047 : $urandom_range(200, 2047);
      // fixed corners
      if (ph == 6) begin
        rng_v = 1;
        lim_v = 1;
        spw_v = 1;
      end
      if (ph == N_PHASES - 1) begin
        cz_v  = 2047;
        spw_v = 31;
        lim_v = 15;
        rng_v = 2047;
      end
      // target mostly reachable so that starts get through
      bound = cz_v - thk_v;
      r = $urandom_range(99);
      if (r < 15) tgt_v = $urandom_range(0, 2047);
      else if (bound > 0) tgt_v = $urandom_range(0, (bound > 2047) ? 2047 : bound);
      else tgt_v = 0;
      write_reg(CFG_CONTAINER_ZERO, CFG_DATA_W'(cz_v));
      write_reg(CFG_FLOATER_THICKNESS, CFG_DATA_W'(thk_v));
      write_reg(CFG_TARGET_LEVEL, CFG_DATA_W'(tgt_v));
      write_reg(CFG_SAMPLES_PER_WIN, CFG_DATA_W'(spw_v));
      write_reg(CFG_LOSS_LIMIT, CFG_DATA_W'(lim_v));
      write_reg(CFG_RANGE_LIMIT, CFG_DATA_W'(rng_v));
      win_v = (spw_v == 0) ? 1 : (spw_v > MAX_WINDOW) ? MAX_WINDOW : spw_v;
      // readings above lo keep the level under the target
      lo = (bound - tgt_v + 1 < 1) ? 1 : bound - tgt_v + 1;

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      // long receiver hold-off while items keep coming
      if (ph == 0) hold_kick <= ~hold_kick;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) begin
          // well-formed fill: start then a run of samples
          send_item(CMD_START, DIST_W'($urandom_range(65535)), 1'($urandom_range(1)));
          sent++;
          len = $urandom_range(1, 3 * win_v + 2);
          repeat (len) begin
            r = $urandom_range(99);
            if (r < 45 && lo < rng_v) smp_mm = DIST_W'($urandom_range(lo, rng_v - 1));
            else if (r < 80 && rng_v > 1) smp_mm = DIST_W'($urandom_range(1, rng_v - 1));
            else if (r < 85) smp_mm = '0;
            else if (r < 90) smp_mm = DIST_W'(rng_v);
            else smp_mm = DIST_W'($urandom_range(65535));
            tmo = ($urandom_range(99) < 8);
            send_item(CMD_SAMPLE, smp_mm, tmo);
            sent++;
          end
          if ($urandom_range(9) == 0) begin
            send_item(CMD_ABORT, DIST_W'($urandom_range(65535)), 1'($urandom_range(1)));
            sent++;
          end
        end else begin
          // noise item
          c = CMD_W'($urandom_range(3));
          send_item(c, DIST_W'($urandom_range(65535)), 1'($urandom_range(1)));
          if (c != CMD_UNDEF) sent++;
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("checked %0d result items for %0d items over %0d settings, %0d windows closed",
             n_checked, n_items, N_PHASES + 1, n_windows);
    $display("stops: %0d target reached, %0d signal lost, %0d aborted, %0d starts rejected",
             n_reached, n_lost, n_aborts, n_rejected);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
